// ----- rtl/msb_pkg.sv -----
// Shared types and constants for the bottom-up merge sorter.
// Depends on nothing; msb_cell and the top level import it.
package msb_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

  // Input word: one list element and its end-of-list flag.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } msb_in_t;

  // Output word: one sorted element and its end-of-list flag.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
  } msb_out_t;

  // Element as it moves along the cell chain.
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] val;
  } msb_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_EMIT
  } msb_state_t;

endpackage

// ----- rtl/msb_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
// Depends on nothing; the payload type is given at instantiation.
interface msb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/msb_cell.sv -----
// One cell of the sorting chain: keeps the smaller element, passes the larger right.
// Depends on msb_pkg.
module msb_cell (
  input  logic              clk,
  input  logic              rst,
  input  msb_pkg::msb_word_t in_link,
  input  logic              shift,
  input  msb_pkg::msb_word_t right_held,
  output msb_pkg::msb_word_t held,
  output msb_pkg::msb_word_t pass
);
  import msb_pkg::*;

  logic                     held_vld;
  logic signed [DATA_W-1:0] held_val;
  logic                     pass_vld;
  logic signed [DATA_W-1:0] pass_val;

  assign held = '{vld: held_vld, val: held_val};
  assign pass = '{vld: pass_vld, val: pass_val};

  // Control bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_vld <= 1'b0;
      pass_vld <= 1'b0;
    end else if (shift) begin
      held_vld <= right_held.vld;
      pass_vld <= 1'b0;
    end else if (in_link.vld) begin
      held_vld <= 1'b1;
      pass_vld <= held_vld;
    end else begin
      pass_vld <= 1'b0;
    end
  end

  // Payload. On a tie the held element stays, so the newcomer moves on.
  always_ff @(posedge clk) begin
    if (shift) begin
      held_val <= right_held.val;
    end else if (in_link.vld) begin
      if (!held_vld) begin
        held_val <= in_link.val;
      end else if (in_link.val < held_val) begin
        held_val <= in_link.val;
        pass_val <= held_val;
      end else begin
        pass_val <= in_link.val;
      end
    end
  end

`ifndef ASSERT_OFF
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    (held_vld && !shift) |=> held_vld)
    else $error("cell lost its element without a shift");
  a_pass_needs_held: assert property (@(posedge clk) disable iff (rst)
    pass_vld |-> held_vld)
    else $error("cell passed an element while empty");
  a_pass_order: assert property (@(posedge clk) disable iff (rst)
    pass_vld |-> (pass_val >= held_val))
    else $error("cell passed an element smaller than the one it kept");
`endif

endmodule

// ----- rtl/merge_sort_bottom_up_top.sv -----
// Top level of the list sorter: control, counters and the chain of sorting cells.
// Depends on msb_pkg, msb_stream_if and msb_cell.
//
// Usage:
//   The item channel carries words {value, last_in}; the result channel carries
//   words {sorted_value, last_out}. Both use valid/ready, a word moving on an edge
//   where both are high. A list is loaded one word per cycle; the word with
//   last_in set closes it. Words beyond MAX_ELEMENTS are dropped, but a dropped
//   word with last_in set still closes the list.
//   Each loaded word enters a row of MAX_ELEMENTS cells; each cell keeps the
//   smaller of what it holds and what arrives and hands the larger one to its
//   right neighbor on the next cycle, so the row stays in ascending order.
//   After the closing word the block waits for the last insertion to settle,
//   then emits the list smallest first from the leftmost cell while the row
//   shifts left, one word per cycle while the receiver is ready; last_out
//   marks the final word.
//   The item channel is not ready while a list settles or is emitted.
//   A stalled receiver simply holds the row: the result word stays on the port.
//   Reset (synchronous, active high) empties the row and returns to loading.
module merge_sort_bottom_up_top #(
  parameter int MAX_ELEMENTS = msb_pkg::MAX_ELEMENTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  msb_stream_if.sink   item,
  msb_stream_if.source result
);
  import msb_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int SW = $clog2(MAX_ELEMENTS);

  msb_state_t    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] settle_cnt, settle_cnt_next;

  logic      item_acc;
  logic      result_acc;
  logic      shift;
  msb_word_t link [MAX_ELEMENTS];
  msb_word_t held [MAX_ELEMENTS];
  msb_word_t tail;

  assign item_acc   = item.valid && item.ready;
  assign result_acc = result.valid && result.ready;
  assign shift      = result_acc;

  // The incoming word feeds the leftmost cell directly; a full row drops it.
  assign link[0] = '{vld: item_acc && (count < CW'(MAX_ELEMENTS)),
                     val: item.data.value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      settle_cnt <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      settle_cnt <= settle_cnt_next;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    settle_cnt_next = settle_cnt;
    item.ready      = 1'b0;
    result.valid    = 1'b0;
    case (state)
      ST_LOAD: begin
        item.ready = 1'b1;
        if (item_acc) begin
          if (count < CW'(MAX_ELEMENTS)) begin
            count_next = count + 1'b1;
          end
          if (item.data.last_in) begin
            settle_cnt_next = '0;
            state_next      = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        // The last insertion ripples along the row of cells until it comes to rest.
        settle_cnt_next = settle_cnt + 1'b1;
        if (settle_cnt == SW'(MAX_ELEMENTS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        result.valid = 1'b1;
        if (result_acc) begin
          count_next = count - 1'b1;
          if (count == CW'(1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign result.data = '{sorted_value: held[0].val, last_out: (count == CW'(1))};

  // The row of cells. Each one hands its larger element right and, while the
  // list is emitted, takes its right neighbor's element.
  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    if (g == MAX_ELEMENTS - 1) begin : g_end
      msb_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .in_link    (link[g]),
        .shift      (shift),
        .right_held ('0),
        .held       (held[g]),
        .pass       (tail)
      );
    end else begin : g_mid
      msb_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .in_link    (link[g]),
        .shift      (shift),
        .right_held (held[g+1]),
        .held       (held[g]),
        .pass       (link[g+1])
      );
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !tail.vld)
    else $error("an element was pushed past the end of the row");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (count != '0) && held[0].vld)
    else $error("emitting from an empty row");
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (result_acc && !result.data.last_out) |=>
      (result.data.sorted_value >= $past(result.data.sorted_value)))
    else $error("sorted output went down");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(item.ready && result.valid))
    else $error("loading and emitting at once");
`endif

endmodule
